// File: src/uer_pkg.sv
package uer_pkg;

    // Fixed field widths of the ranging block.
    localparam int MS_W       = 10;
    localparam int PING_W     = 4;
    localparam int SUM_W      = 14;
    localparam int FRAC_W     = 8;
    localparam int DIST_W     = 18;
    localparam int TPC_W      = 16;
    localparam int TRIG_W     = 16;
    localparam int CM_W       = 10;
    localparam int GAP_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MEAN_DVD_W = SUM_W + FRAC_W;
    localparam int STEP_W     = 3;

    // Largest number of pings averaged in one measurement.
    localparam int MAX_PINGS = 8;

    // Register values after reset.
    localparam logic [TPC_W-1:0]  RST_TICKS_PER_CM = 16'd72;
    localparam logic [MS_W-1:0]   RST_TIMEOUT_MS   = 10'd100;
    localparam logic [CM_W-1:0]   RST_MIN_CM       = 10'd2;
    localparam logic [CM_W-1:0]   RST_MAX_CM       = 10'd400;
    localparam logic [PING_W-1:0] RST_PING_COUNT   = 4'd5;
    localparam logic [GAP_W-1:0]  RST_GAP_MS       = 8'd20;
    localparam logic [TRIG_W-1:0] RST_TRIG_TICKS   = 16'd100;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LOW  = 3'd1,
        PH_TRIG = 3'd2,
        PH_WAIT = 3'd3,
        PH_ECHO = 3'd4,
        PH_GAP  = 3'd5
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_CM = 3'd0,
        REG_TIMEOUT_MS   = 3'd1,
        REG_MIN_CM       = 3'd2,
        REG_MAX_CM       = 3'd3,
        REG_PING_COUNT   = 3'd4,
        REG_GAP_MS       = 3'd5,
        REG_TRIG_TICKS   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [TPC_W-1:0]  ticks_per_cm;
        logic [MS_W-1:0]   timeout_ms;
        logic [CM_W-1:0]   min_cm;
        logic [CM_W-1:0]   max_cm;
        logic [PING_W-1:0] ping_count;
        logic [GAP_W-1:0]  gap_ms;
        logic [TRIG_W-1:0] trig_ticks;
    } cfg_t;

    // Microcode fields.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_LOAD_DIST,
        OP_LOAD_MEAN,
        OP_DIV_STEP,
        OP_ACCUM
    } uop_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_DIV_LOOP,
        J_DISPATCH
    } ujmp_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_PLAIN,
        EMIT_MEAN
    } emit_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH     = 3'd0;
    localparam step_t STEP_DIST_LOAD = 3'd1;
    localparam step_t STEP_DIST_RUN  = 3'd2;
    localparam step_t STEP_DIST_ACC  = 3'd3;
    localparam step_t STEP_MEAN_LOAD = 3'd4;
    localparam step_t STEP_MEAN_RUN  = 3'd5;
    localparam step_t STEP_MEAN_OUT  = 3'd6;

    typedef struct packed {
        logic  rdy;
        uop_t  op;
        ujmp_t jmp;
        step_t target;
        emit_t emit;
    } ucode_t;

    // Control strobes from the sequencer to the datapath and divider.
    typedef struct packed {
        logic tick;
        logic div_load;
        logic div_mean;
        logic div_step;
        logic accum;
        logic emit;
        logic emit_mean;
    } ctl_t;

    // Status from the datapath that steers the dispatch jump.
    typedef struct packed {
        logic dist_req;
        logic mean_req;
    } stat_t;

    typedef struct packed {
        logic              trig_level;
        logic              busy_res;
        logic              done_res;
        logic              no_echo;
        logic [DIST_W-1:0] distance_q8;
        logic [PING_W-1:0] valid_pings;
    } res_t;

    // The control program, one word per step.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_FETCH:
                w = '{rdy: 1'b1, op: OP_TICK, jmp: J_DISPATCH,
                      target: STEP_FETCH, emit: EMIT_PLAIN};
            STEP_DIST_LOAD:
                w = '{rdy: 1'b0, op: OP_LOAD_DIST, jmp: J_NEXT,
                      target: STEP_FETCH, emit: EMIT_NONE};
            STEP_DIST_RUN:
                w = '{rdy: 1'b0, op: OP_DIV_STEP, jmp: J_DIV_LOOP,
                      target: STEP_FETCH, emit: EMIT_NONE};
            STEP_DIST_ACC:
                w = '{rdy: 1'b0, op: OP_ACCUM, jmp: J_GOTO,
                      target: STEP_FETCH, emit: EMIT_PLAIN};
            STEP_MEAN_LOAD:
                w = '{rdy: 1'b0, op: OP_LOAD_MEAN, jmp: J_NEXT,
                      target: STEP_FETCH, emit: EMIT_NONE};
            STEP_MEAN_RUN:
                w = '{rdy: 1'b0, op: OP_DIV_STEP, jmp: J_DIV_LOOP,
                      target: STEP_FETCH, emit: EMIT_NONE};
            STEP_MEAN_OUT:
                w = '{rdy: 1'b0, op: OP_NONE, jmp: J_GOTO,
                      target: STEP_FETCH, emit: EMIT_MEAN};
            default:
                w = '{rdy: 1'b0, op: OP_NONE, jmp: J_GOTO,
                      target: STEP_FETCH, emit: EMIT_NONE};
        endcase
        return w;
    endfunction

endpackage

// File: src/uer_tick_if.sv
interface uer_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;
    logic ms_strobe;

    modport source (output valid, output start_req, output echo_level,
                    output ms_strobe, input ready);
    modport sink (input valid, input start_req, input echo_level,
                  input ms_strobe, output ready);
endinterface

// File: src/uer_result_if.sv
interface uer_result_if;
    logic                           valid;
    logic                           ready;
    logic                           trig_level;
    logic                           busy_res;
    logic                           done_res;
    logic                           no_echo;
    logic [uer_pkg::DIST_W-1:0]     distance_q8;
    logic [uer_pkg::PING_W-1:0]     valid_pings;

    modport source (output valid, output trig_level, output busy_res, output done_res,
                    output no_echo, output distance_q8, output valid_pings,
                    input ready);
    modport sink (input valid, input trig_level, input busy_res, input done_res,
                  input no_echo, input distance_q8, input valid_pings,
                  output ready);
endinterface

// File: src/uer_cfg_if.sv
interface uer_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [uer_pkg::CFG_IDX_W-1:0]     index;
    logic [uer_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/uer_cfg_regs.sv
module uer_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    uer_cfg_if.sink       cfg,
    output uer_pkg::cfg_t conf
);

    uer_pkg::cfg_t conf_reg;
    uer_pkg::cfg_t conf_next;

    assign cfg.ready = 1'b1;
    assign conf      = conf_reg;

    // Register write decode; indexes past the list are dropped.
    always_comb
    begin
        conf_next = conf_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                uer_pkg::REG_TICKS_PER_CM: conf_next.ticks_per_cm = cfg.data[uer_pkg::TPC_W-1:0];
                uer_pkg::REG_TIMEOUT_MS:   conf_next.timeout_ms   = cfg.data[uer_pkg::MS_W-1:0];
                uer_pkg::REG_MIN_CM:       conf_next.min_cm       = cfg.data[uer_pkg::CM_W-1:0];
                uer_pkg::REG_MAX_CM:       conf_next.max_cm       = cfg.data[uer_pkg::CM_W-1:0];
                uer_pkg::REG_PING_COUNT:   conf_next.ping_count   = cfg.data[uer_pkg::PING_W-1:0];
                uer_pkg::REG_GAP_MS:       conf_next.gap_ms       = cfg.data[uer_pkg::GAP_W-1:0];
                uer_pkg::REG_TRIG_TICKS:   conf_next.trig_ticks   = cfg.data[uer_pkg::TRIG_W-1:0];
                default:                   conf_next = conf_reg;
            endcase
        end
    end

    // Configuration registers with their documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_reg.ticks_per_cm <= uer_pkg::RST_TICKS_PER_CM;
            conf_reg.timeout_ms   <= uer_pkg::RST_TIMEOUT_MS;
            conf_reg.min_cm       <= uer_pkg::RST_MIN_CM;
            conf_reg.max_cm       <= uer_pkg::RST_MAX_CM;
            conf_reg.ping_count   <= uer_pkg::RST_PING_COUNT;
            conf_reg.gap_ms       <= uer_pkg::RST_GAP_MS;
            conf_reg.trig_ticks   <= uer_pkg::RST_TRIG_TICKS;
        end
        else
        begin
            conf_reg <= conf_next;
        end
    end

endmodule

// File: src/uer_divider.sv
module uer_divider #(
    parameter int DVD_W = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic                      step,
    input  logic [DVD_W-1:0]          dividend,
    input  logic [uer_pkg::TPC_W-1:0] divisor,
    output logic [DVD_W-1:0]          quotient,
    output logic                      last
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]          quo_reg;
    logic [DVD_W-1:0]          quo_next;
    logic [uer_pkg::TPC_W:0]   rem_reg;
    logic [uer_pkg::TPC_W:0]   rem_next;
    logic [uer_pkg::TPC_W-1:0] dsr_reg;
    logic [uer_pkg::TPC_W-1:0] dsr_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic [uer_pkg::TPC_W:0]   rem_sh;

    assign quotient = quo_reg;
    assign last     = (cnt_reg == CNT_W'(1));

    // Restoring division, one quotient bit per step, MSB first.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        rem_sh   = {rem_reg[uer_pkg::TPC_W-1:0], quo_reg[DVD_W-1]};
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (step)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sh - {1'b0, dsr_reg};
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Bit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

// File: src/uer_sequencer.sv
module uer_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_free,
    input  uer_pkg::stat_t stat,
    input  logic           div_last,
    output logic           in_ready,
    output uer_pkg::ctl_t  ctl
);

    uer_pkg::step_t  step_reg;
    uer_pkg::step_t  step_next;
    uer_pkg::ucode_t w;
    logic            fire;
    logic            hold;
    logic            divert;

    assign w        = uer_pkg::ucode_rom(step_reg);
    assign in_ready = w.rdy && out_free;
    assign fire     = in_ready && in_valid;

    // A fetch step waits for a transaction, an output step for a free slot.
    assign hold = w.rdy ? !fire : ((w.emit != uer_pkg::EMIT_NONE) && !out_free);

    // The dispatch jump leaves the fetch step when a division must follow.
    assign divert = (w.jmp == uer_pkg::J_DISPATCH) && (stat.dist_req || stat.mean_req);

    // Decode of the control word into strobes.
    always_comb
    begin
        ctl.tick      = !hold && (w.op == uer_pkg::OP_TICK);
        ctl.div_load  = !hold && ((w.op == uer_pkg::OP_LOAD_DIST) ||
                                  (w.op == uer_pkg::OP_LOAD_MEAN));
        ctl.div_mean  = (w.op == uer_pkg::OP_LOAD_MEAN);
        ctl.div_step  = !hold && (w.op == uer_pkg::OP_DIV_STEP);
        ctl.accum     = !hold && (w.op == uer_pkg::OP_ACCUM);
        ctl.emit      = !hold && !divert && (w.emit != uer_pkg::EMIT_NONE);
        ctl.emit_mean = (w.emit == uer_pkg::EMIT_MEAN);
    end

    // Next step selection.
    always_comb
    begin
        step_next = step_reg;
        if (!hold)
        begin
            unique case (w.jmp)
                uer_pkg::J_NEXT:
                    step_next = uer_pkg::STEP_W'(step_reg + 1'b1);
                uer_pkg::J_GOTO:
                    step_next = w.target;
                uer_pkg::J_DIV_LOOP:
                    step_next = div_last ? uer_pkg::STEP_W'(step_reg + 1'b1) : step_reg;
                uer_pkg::J_DISPATCH:
                begin
                    priority if (stat.dist_req)
                        step_next = uer_pkg::STEP_DIST_LOAD;
                    else if (stat.mean_req)
                        step_next = uer_pkg::STEP_MEAN_LOAD;
                    else
                        step_next = w.target;
                end
                default:
                    step_next = uer_pkg::STEP_FETCH;
            endcase
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= uer_pkg::STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: src/uer_datapath.sv
module uer_datapath #(
    parameter int COUNT_WIDTH = 24,
    parameter int DVD_W       = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start_req,
    input  logic                      echo_level,
    input  logic                      ms_strobe,
    input  uer_pkg::cfg_t             conf,
    input  uer_pkg::ctl_t             ctl,
    input  logic [DVD_W-1:0]          quotient,
    output logic [DVD_W-1:0]          dividend,
    output logic [uer_pkg::TPC_W-1:0] divisor,
    output uer_pkg::stat_t            stat,
    output uer_pkg::res_t             res
);

    uer_pkg::phase_t                phase_reg, phase_next, tk_phase;
    logic [COUNT_WIDTH-1:0]         tick_reg, tick_next, tk_tick, tick_inc;
    logic [uer_pkg::MS_W-1:0]       ms_reg, ms_next, tk_ms, ms_inc, gap_ms;
    logic [uer_pkg::PING_W-1:0]     ping_reg, ping_next, tk_ping, ping_inc, pings;
    logic [uer_pkg::PING_W-1:0]     valid_reg, valid_next, tk_valid;
    logic [uer_pkg::SUM_W-1:0]      sum_reg, sum_next, tk_sum;
    logic                           done_reg, done_next, tk_done;
    logic [uer_pkg::TRIG_W-1:0]     trig_len;
    logic                           timed_out;
    logic                           in_range;

    assign tick_inc  = tick_reg + COUNT_WIDTH'(1);
    assign ms_inc    = ms_reg + uer_pkg::MS_W'(1);
    assign ping_inc  = ping_reg + uer_pkg::PING_W'(1);
    assign trig_len  = (conf.trig_ticks == '0) ? uer_pkg::TRIG_W'(1) : conf.trig_ticks;
    assign timed_out = ms_strobe && (ms_reg >= conf.timeout_ms);
    assign in_range  = (quotient >= DVD_W'(conf.min_cm)) && (quotient <= DVD_W'(conf.max_cm));

    // Ping count clamped to one through the largest supported count.
    always_comb
    begin
        priority if (conf.ping_count == '0)
            pings = uer_pkg::PING_W'(1);
        else if (conf.ping_count > uer_pkg::PING_W'(uer_pkg::MAX_PINGS))
            pings = uer_pkg::PING_W'(uer_pkg::MAX_PINGS);
        else
            pings = conf.ping_count;
    end

    // Division operands: echo count by calibration, or scaled sum by valid ping count.
    always_comb
    begin
        if (ctl.div_mean)
        begin
            dividend = DVD_W'({sum_reg, {uer_pkg::FRAC_W{1'b0}}});
            divisor  = uer_pkg::TPC_W'(valid_reg);
        end
        else
        begin
            dividend = DVD_W'(tick_reg);
            divisor  = (conf.ticks_per_cm == '0) ? uer_pkg::TPC_W'(1) : conf.ticks_per_cm;
        end
    end

    // One tick of the ranging state machine.
    always_comb
    begin
        tk_phase      = phase_reg;
        tk_tick       = tick_reg;
        tk_ms         = ms_reg;
        tk_ping       = ping_reg;
        tk_valid      = valid_reg;
        tk_sum        = sum_reg;
        tk_done       = 1'b0;
        stat.dist_req = 1'b0;
        gap_ms        = (ms_strobe && (ms_reg != '1)) ? ms_inc : ms_reg;
        unique case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (start_req)
                begin
                    tk_phase = uer_pkg::PH_LOW;
                    tk_tick  = '0;
                    tk_ms    = '0;
                    tk_ping  = '0;
                    tk_valid = '0;
                    tk_sum   = '0;
                end
            end
            uer_pkg::PH_LOW:
            begin
                if (ms_strobe)
                begin
                    tk_phase = uer_pkg::PH_TRIG;
                    tk_tick  = '0;
                end
            end
            uer_pkg::PH_TRIG:
            begin
                if ((tick_inc >= COUNT_WIDTH'(trig_len)) || (tick_inc == '0))
                begin
                    tk_phase = uer_pkg::PH_WAIT;
                    tk_tick  = '0;
                    tk_ms    = '0;
                end
                else
                begin
                    tk_tick = tick_inc;
                end
            end
            uer_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    // The rising tick counts as the first echo tick.
                    tk_phase = uer_pkg::PH_ECHO;
                    tk_tick  = COUNT_WIDTH'(1);
                    tk_ms    = '0;
                    if (ms_strobe)
                    begin
                        if (conf.timeout_ms == '0)
                            tk_phase = uer_pkg::PH_GAP;
                        else
                            tk_ms = uer_pkg::MS_W'(1);
                    end
                end
                else if (ms_strobe)
                begin
                    if (timed_out)
                    begin
                        tk_phase = uer_pkg::PH_GAP;
                        tk_ms    = '0;
                    end
                    else
                    begin
                        tk_ms = ms_inc;
                    end
                end
            end
            uer_pkg::PH_ECHO:
            begin
                if (echo_level)
                begin
                    if (tick_reg != '1)
                        tk_tick = tick_inc;
                    if (ms_strobe)
                    begin
                        if (timed_out)
                        begin
                            tk_phase = uer_pkg::PH_GAP;
                            tk_ms    = '0;
                        end
                        else
                        begin
                            tk_ms = ms_inc;
                        end
                    end
                end
                else
                begin
                    // Echo fell: the count goes to the divider.
                    stat.dist_req = 1'b1;
                    tk_phase      = uer_pkg::PH_GAP;
                    tk_ms         = '0;
                end
            end
            uer_pkg::PH_GAP:
            begin
                if (gap_ms >= uer_pkg::MS_W'(conf.gap_ms))
                begin
                    tk_ping = ping_inc;
                    tk_ms   = '0;
                    tk_tick = '0;
                    if (ping_inc >= pings)
                    begin
                        tk_phase = uer_pkg::PH_IDLE;
                        tk_done  = 1'b1;
                    end
                    else
                    begin
                        tk_phase = uer_pkg::PH_LOW;
                    end
                end
                else
                begin
                    tk_ms = gap_ms;
                end
            end
            default:
            begin
                tk_phase = uer_pkg::PH_IDLE;
            end
        endcase
        stat.mean_req = tk_done && (tk_valid != '0);
    end

    // Register update: a tick, an accumulation of a finished in-range ping, or hold.
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        ms_next    = ms_reg;
        ping_next  = ping_reg;
        valid_next = valid_reg;
        sum_next   = sum_reg;
        done_next  = done_reg;
        if (ctl.tick)
        begin
            phase_next = tk_phase;
            tick_next  = tk_tick;
            ms_next    = tk_ms;
            ping_next  = tk_ping;
            valid_next = tk_valid;
            sum_next   = tk_sum;
            done_next  = tk_done;
        end
        else if (ctl.accum && in_range)
        begin
            sum_next   = sum_reg + uer_pkg::SUM_W'(quotient[uer_pkg::CM_W-1:0]);
            valid_next = valid_reg + uer_pkg::PING_W'(1);
        end
    end

    // Result fields are taken from the updated state.
    always_comb
    begin
        res.trig_level  = (phase_next == uer_pkg::PH_TRIG);
        res.busy_res    = (phase_next != uer_pkg::PH_IDLE);
        res.done_res    = done_next;
        res.no_echo     = done_next && (valid_next == '0);
        res.valid_pings = done_next ? valid_next : '0;
        res.distance_q8 = ctl.emit_mean ? quotient[uer_pkg::DIST_W-1:0] : '0;
    end

    // Ranging state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uer_pkg::PH_IDLE;
            tick_reg  <= '0;
            ms_reg    <= '0;
            ping_reg  <= '0;
            valid_reg <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            ms_reg    <= ms_next;
            ping_reg  <= ping_next;
            valid_reg <= valid_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

endmodule

// File: src/ultrasonic_echo_ranger_unit.sv
// Channel  Role    Payload                                              Transfer
// tick     sink    start_req, echo_level, ms_strobe                      valid & ready
// result   source  trig_level, busy_res, done_res, no_echo,              valid & ready
//                  distance_q8, valid_pings
// cfg      sink    index, data                                           valid & ready
//
// Most tick transactions are handled in the fetch step of the microprogram.
// A tick that ends a ping's echo, and a tick that finishes a measurement with at
// least one valid ping, run the shared restoring divider, whose width DVD_W is
// the larger of COUNT_WIDTH and 22. Reset clears the sequencer, the ranging
// state and the output slot, and loads the register defaults; there is no
// clearing pass. One result waits in the output register; a new tick is taken in
// the fetch step when that slot is empty or being drained.
module ultrasonic_echo_ranger_unit #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    uer_tick_if.sink      tick,
    uer_result_if.source  result,
    uer_cfg_if.sink       cfg
);

    localparam int DVD_W = (COUNT_WIDTH > uer_pkg::MEAN_DVD_W) ? COUNT_WIDTH
                                                              : uer_pkg::MEAN_DVD_W;

    uer_pkg::cfg_t             conf;
    uer_pkg::ctl_t             ctl;
    uer_pkg::stat_t            stat;
    uer_pkg::res_t             res;
    uer_pkg::res_t             res_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_free;
    logic                      div_last;
    logic [DVD_W-1:0]          quotient;
    logic [DVD_W-1:0]          dividend;
    logic [uer_pkg::TPC_W-1:0] divisor;

    assign out_free = !out_valid_reg || result.ready;

    uer_cfg_regs u_cfg_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .conf (conf)
    );

    uer_sequencer u_sequencer (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(tick.valid),
        .out_free(out_free),
        .stat    (stat),
        .div_last(div_last),
        .in_ready(tick.ready),
        .ctl     (ctl)
    );

    uer_divider #(
        .DVD_W(DVD_W)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (ctl.div_load),
        .step    (ctl.div_step),
        .dividend(dividend),
        .divisor (divisor),
        .quotient(quotient),
        .last    (div_last)
    );

    uer_datapath #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .DVD_W      (DVD_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_req (tick.start_req),
        .echo_level(tick.echo_level),
        .ms_strobe (tick.ms_strobe),
        .conf      (conf),
        .ctl       (ctl),
        .quotient  (quotient),
        .dividend  (dividend),
        .divisor   (divisor),
        .stat      (stat),
        .res       (res)
    );

    // Output slot occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            res_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.trig_level  = res_reg.trig_level;
    assign result.busy_res    = res_reg.busy_res;
    assign result.done_res    = res_reg.done_res;
    assign result.no_echo     = res_reg.no_echo;
    assign result.distance_q8 = res_reg.distance_q8;
    assign result.valid_pings = res_reg.valid_pings;

endmodule
